FILE: hdl/mtf_word_index_decoder_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef MTF_WORD_INDEX_DECODER_MACROS_SVH
`define MTF_WORD_INDEX_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define MTF_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtf decoder assertion failed");
`define MTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtf decoder assertion failed");
`else
`define MTF_ASSERT(label, clk, rst_n, ante, cons)
`define MTF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/mtf_pkg.sv
package mtf_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int BYTE_W     = 8;
    localparam int ORD_W      = 8;
    localparam int IDX_W      = 17;
    localparam int KIND_W     = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // byte coding
    localparam int BYTE_NL       = 10;
    localparam int BYTE_TEXT_END = 128;
    localparam int SHORT_BASE    = 129;
    localparam int ESC_SHORT     = 249;
    localparam int ESC_LONG      = 250;
    localparam int SHORT_ESC_OFS = 120;
    localparam int LONG_ESC_OFS  = 375;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEWLINE = 2'd0,
        KIND_NEW     = 2'd1,
        KIND_REPEAT  = 2'd2,
        KIND_FULL    = 2'd3
    } t_kind;

    typedef struct packed {
        logic             clr;
        logic             newline;
        logic [IDX_W-1:0] idx;
    } t_token;

endpackage

FILE: hdl/mtf_word_index_decoder.sv
// Move-to-front word index decoder: bytes in, newline / word tokens out.
// Front parser takes one byte per cycle while the 4-deep token queue is not full, and pushes its tokens there.
// Back end per token: newline, list-full and first new word go straight to the output register;
// a repeat first reads its entry (ST_RDSEL), and a repeat at index k>0 or a new word with n>0 listed
// then shifts the list memory one entry per cycle (ST_SHIFT) and writes the front entry (ST_FRONT).
// Reset (i_rst_n low, synchronous) empties the queue, parser and list.
module mtf_word_index_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mtf_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_stream_start,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mtf_pkg::KIND_W-1:0]        o_token_kind,
    output logic [mtf_pkg::ORD_W-1:0]         o_word_ordinal,
    output logic [mtf_pkg::IDX_W-1:0]         o_code_index
);
    import mtf_pkg::*;

    t_token  push_tok, head_tok;
    logic    push, pop, q_empty, q_full;

    mtf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_stream_start (i_stream_start),
        .o_push         (push),
        .o_token        (push_tok),
        .i_full         (q_full)
    );

    mtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_tok),
        .i_pop   (pop),
        .o_head  (head_tok),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mtf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_tok),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_word_ordinal (o_word_ordinal),
        .o_code_index   (o_code_index)
    );

endmodule

FILE: hdl/mtf_front.sv
module mtf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mtf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_stream_start,
    output logic                         o_push,
    output mtf_pkg::t_token              o_token,
    input  logic                         i_full
);
    import mtf_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SHORT,
        PH_LONG_HI,
        PH_LONG_LO
    } t_phase;

    t_phase              r_phase, n_phase, ph;
    logic [BYTE_W-1:0]   r_hi, n_hi, eh;
    logic                r_pend_clr;
    logic                has_tok;
    logic                accept;
    t_token              tok;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && has_tok;
    assign o_token = tok;

    always_comb begin
        ph          = i_stream_start ? PH_IDLE : r_phase;
        eh          = i_stream_start ? '0 : r_hi;
        n_phase     = ph;
        n_hi        = eh;
        has_tok     = 1'b0;
        tok.clr     = r_pend_clr || i_stream_start;
        tok.newline = 1'b0;
        tok.idx     = '0;
        unique case (ph)
            PH_SHORT: begin
                n_phase = PH_IDLE;
                has_tok = 1'b1;
                tok.idx = IDX_W'(i_data_byte) + IDX_W'(SHORT_ESC_OFS);
            end
            PH_LONG_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_LONG_LO;
            end
            PH_LONG_LO: begin
                n_phase = PH_IDLE;
                n_hi    = '0;
                has_tok = 1'b1;
                tok.idx = IDX_W'({eh, i_data_byte}) + IDX_W'(LONG_ESC_OFS);
            end
            default: begin
                priority if (i_data_byte == BYTE_W'(BYTE_NL) ||
                             i_data_byte == BYTE_W'(BYTE_TEXT_END)) begin
                    has_tok     = 1'b1;
                    tok.newline = 1'b1;
                end else if (i_data_byte < BYTE_W'(BYTE_TEXT_END)) begin
                    has_tok = 1'b0;
                end else if (i_data_byte == BYTE_W'(ESC_SHORT)) begin
                    n_phase = PH_SHORT;
                end else if (i_data_byte == BYTE_W'(ESC_LONG)) begin
                    n_phase = PH_LONG_HI;
                end else begin
                    has_tok = 1'b1;
                    tok.idx = IDX_W'(i_data_byte) - IDX_W'(SHORT_BASE);
                end
            end
        endcase
    end

    // a stream start with no word of its own rides on the next token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hi       <= '0;
            r_pend_clr <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_hi       <= n_hi;
            r_pend_clr <= has_tok ? 1'b0 : (r_pend_clr || i_stream_start);
        end
    end

endmodule

FILE: hdl/mtf_queue.sv
module mtf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mtf_pkg::t_token  i_token,
    input  logic             i_pop,
    output mtf_pkg::t_token  o_head,
    output logic             o_empty,
    output logic             o_full
);
    import mtf_pkg::*;

`include "mtf_word_index_decoder_macros.svh"

    t_token               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp, r_rp;
    logic [Q_PTR_W:0]     r_cnt;
    logic                 do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_head  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `MTF_ASSERT(a_q_no_overrun, i_clk, i_rst_n, i_push, !o_full)
    `MTF_ASSERT(a_q_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (Q_PTR_W+1)'(Q_DEPTH))

endmodule

FILE: hdl/mtf_back.sv
module mtf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtf_pkg::t_token               i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mtf_pkg::KIND_W-1:0]    o_token_kind,
    output logic [mtf_pkg::ORD_W-1:0]     o_word_ordinal,
    output logic [mtf_pkg::IDX_W-1:0]     o_code_index
);
    import mtf_pkg::*;

`include "mtf_word_index_decoder_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDSEL,
        ST_SHIFT,
        ST_FRONT,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_pos;
    logic [ORD_W-1:0]    r_ord;
    logic [KIND_W-1:0]   r_kind;
    logic [IDX_W-1:0]    r_idx;

    logic [ORD_W-1:0]    r_mem [LIST_DEPTH];
    logic [ORD_W-1:0]    r_rdata;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_wa, mem_ra;
    logic [ORD_W-1:0]    mem_wd;

    logic [CNT_W-1:0]    c_eff;
    logic                is_new, is_full;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign c_eff   = i_head.clr ? '0 : r_count;
    assign is_new  = i_head.idx >= IDX_W'(c_eff);
    assign is_full = c_eff == CNT_W'(LIST_DEPTH);

    // one read and one write a cycle; the shift walks down from the slot being filled
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = '0;
        mem_ra = '0;
        mem_wd = r_ord;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && !i_head.newline) begin
                    if (is_new && !is_full) begin
                        if (c_eff == '0) begin
                            mem_we = 1'b1;
                            mem_wd = ORD_W'(c_eff);
                        end else begin
                            mem_re = 1'b1;
                            mem_ra = ADDR_W'(c_eff - 1'b1);
                        end
                    end else if (!is_new) begin
                        mem_re = 1'b1;
                        mem_ra = ADDR_W'(i_head.idx);
                    end
                end
            end
            ST_RDSEL: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                    mem_wd = r_rdata;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_pos - 1'b1;
                end
            end
            ST_SHIFT: begin
                mem_we = 1'b1;
                mem_wa = r_pos;
                mem_wd = r_rdata;
                if (r_pos != ADDR_W'(1)) begin
                    mem_re = 1'b1;
                    mem_ra = r_pos - ADDR_W'(2);
                end
            end
            ST_FRONT: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            // a word loaded in ST_DONE replaces the one taken this cycle
            if (o_valid && i_ready && r_state != ST_DONE) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        priority if (i_head.newline) begin
                            r_count <= c_eff;
                            r_kind  <= KIND_NEWLINE;
                            r_idx   <= '0;
                            r_ord   <= '0;
                            r_state <= ST_DONE;
                        end else if (is_new && is_full) begin
                            r_count <= c_eff;
                            r_kind  <= KIND_FULL;
                            r_idx   <= i_head.idx;
                            r_ord   <= '0;
                            r_state <= ST_DONE;
                        end else if (is_new) begin
                            r_kind  <= KIND_NEW;
                            r_idx   <= i_head.idx;
                            r_ord   <= ORD_W'(c_eff);
                            r_count <= c_eff + 1'b1;
                            r_pos   <= ADDR_W'(c_eff);
                            r_state <= (c_eff == '0) ? ST_DONE : ST_SHIFT;
                        end else begin
                            r_count <= c_eff;
                            r_kind  <= KIND_REPEAT;
                            r_idx   <= i_head.idx;
                            r_ord   <= '0;
                            r_pos   <= ADDR_W'(i_head.idx);
                            r_state <= ST_RDSEL;
                        end
                    end
                end
                ST_RDSEL: begin
                    r_ord   <= r_rdata;
                    r_state <= (r_pos == '0) ? ST_DONE : ST_SHIFT;
                end
                ST_SHIFT: begin
                    r_pos <= r_pos - 1'b1;
                    if (r_pos == ADDR_W'(1)) begin
                        r_state <= ST_FRONT;
                    end
                end
                ST_FRONT: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid        <= 1'b1;
                        o_token_kind   <= r_kind;
                        o_word_ordinal <= r_ord;
                        o_code_index   <= r_idx;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `MTF_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(LIST_DEPTH))
    `MTF_ASSERT(a_shift_pos, i_clk, i_rst_n, r_state == ST_SHIFT, r_pos != '0)
    `MTF_ASSERT(a_newline_zero, i_clk, i_rst_n, o_valid && o_token_kind == KIND_NEWLINE, o_word_ordinal == '0 && o_code_index == '0)
    `MTF_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != ST_IDLE)

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mtf_pkg::*;

    localparam int RUN_LIMIT   = 1_500_000;
    localparam int N_ITEMS     = 900;
    localparam int TAIL_ITEMS  = 120;
    localparam int STALL_LONG  = 600;
    localparam int SHORT_LAST  = ESC_SHORT - 1 - SHORT_BASE;  // 119
    localparam int MAX_INDEX   = LONG_ESC_OFS + 65535;
    localparam int MAX_PRINTS  = 40;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SHORT_ARG,
        PH_LONG_HI,
        PH_LONG_LO
    } t_phase;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              st;
    } t_in_word;

    typedef struct {
        t_kind            kind;
        logic [ORD_W-1:0] ord;
        logic [IDX_W-1:0] idx;
    } t_token_out;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [BYTE_W-1:0]  data_byte    = '0;
    logic               stream_start = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [KIND_W-1:0]  token_kind;
    logic [ORD_W-1:0]   word_ordinal;
    logic [IDX_W-1:0]   code_index;

    mtf_word_index_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_stream_start (stream_start),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_token_kind   (token_kind),
        .o_word_ordinal (word_ordinal),
        .o_code_index   (code_index)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- decoder shadow state ----------------
    t_phase           parse_st = PH_IDLE;
    logic [7:0]       esc_hi   = '0;
    int               list_len = 0;
    logic [ORD_W-1:0] ord_list [LIST_DEPTH];

    t_in_word   pending [$];
    t_token_out expected_tokens [$];
    int         n_errors = 0;
    int         n_sent   = 0;
    int         n_seen   = 0;
    int         gen_len  = 0;

    function automatic void move_to_front(input int unsigned idx, output t_token_out w);
        logic [ORD_W-1:0] ord;
        w.idx = idx[IDX_W-1:0];
        if (idx >= list_len) begin
            if (list_len >= LIST_DEPTH) begin
                // list full: nothing moves
                w.kind = KIND_FULL;
                w.ord  = '0;
                return;
            end
            ord = list_len[ORD_W-1:0];
            for (int i = list_len; i > 0; i--)
                ord_list[i] = ord_list[i-1];
            ord_list[0] = ord;
            list_len++;
            w.kind = KIND_NEW;
            w.ord  = ord;
            return;
        end
        ord = ord_list[idx];
        for (int i = idx; i > 0; i--)
            ord_list[i] = ord_list[i-1];
        ord_list[0] = ord;
        w.kind = KIND_REPEAT;
        w.ord  = ord;
    endfunction

    // Returns 1 when the byte produces a token.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic st,
                                       output t_token_out w);
        w = '{KIND_NEWLINE, '0, '0};
        if (st) begin
            parse_st = PH_IDLE;
            esc_hi   = '0;
            list_len = 0;
        end
        case (parse_st)
            PH_SHORT_ARG: begin
                parse_st = PH_IDLE;
                move_to_front(b + SHORT_ESC_OFS, w);
                return 1'b1;
            end
            PH_LONG_HI: begin
                esc_hi   = b;
                parse_st = PH_LONG_LO;
                return 1'b0;
            end
            PH_LONG_LO: begin
                parse_st = PH_IDLE;
                move_to_front(esc_hi * 256 + b + LONG_ESC_OFS, w);
                esc_hi = '0;
                return 1'b1;
            end
            default: ;
        endcase
        if (b == BYTE_NL || b == BYTE_TEXT_END)
            return 1'b1;
        if (b < BYTE_TEXT_END)
            return 1'b0;
        if (b == ESC_SHORT) begin
            parse_st = PH_SHORT_ARG;
            return 1'b0;
        end
        if (b == ESC_LONG) begin
            parse_st = PH_LONG_HI;
            return 1'b0;
        end
        move_to_front(b - SHORT_BASE, w);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS)
            $display("mismatch @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // ---------------- stimulus generation ----------------
    task automatic push_byte(input int v, input bit st);
        pending.push_back('{v[BYTE_W-1:0], st});
    endtask

    // Encode one index with the shortest or an alternate legal form.
    task automatic add_code(input int idx, input bit st);
        int v;
        if (st)
            gen_len = 0;
        if (idx <= SHORT_LAST ||
            (idx >= ESC_LONG + 1 - SHORT_BASE && idx <= 255 - SHORT_BASE &&
             $urandom_range(0, 1) == 1)) begin
            push_byte(idx + SHORT_BASE, st);
        end else if (idx <= LONG_ESC_OFS) begin
            push_byte(ESC_SHORT, st);
            push_byte(idx - SHORT_ESC_OFS, 1'b0);
        end else begin
            v = idx - LONG_ESC_OFS;
            push_byte(ESC_LONG, st);
            push_byte(v >> 8, 1'b0);
            push_byte(v & 255, 1'b0);
        end
        if (idx >= gen_len && gen_len < LIST_DEPTH)
            gen_len++;
    endtask

    task automatic add_token(input bit st);
        int r;
        if (st)
            gen_len = 0;
        r = $urandom_range(0, 99);
        if (r < 8)
            push_byte($urandom_range(0, BYTE_TEXT_END - 1), st);
        else if (r < 14)
            push_byte($urandom_range(0, 1) ? BYTE_NL : BYTE_TEXT_END, st);
        else if (r < 60 && gen_len > 0) begin
            if ($urandom_range(0, 1))
                add_code($urandom_range(0, gen_len - 1), st);
            else
                add_code($urandom_range(0, (gen_len > 8) ? 7 : gen_len - 1), st);
        end else if (r < 95)
            add_code($urandom_range(gen_len, gen_len + 140), st);
        else
            add_code($urandom_range(LONG_ESC_OFS + 1, MAX_INDEX), st);
    endtask

    task automatic add_streams(input int upto);
        int n;
        while (pending.size() < upto) begin
            n = $urandom_range(20, 120);
            // an escape cut off by a new stream
            if ($urandom_range(0, 3) == 0) begin
                push_byte($urandom_range(0, 1) ? ESC_SHORT : ESC_LONG, 1'b0);
                if ($urandom_range(0, 1))
                    push_byte($urandom_range(0, 255), 1'b0);
            end
            add_token(1'b1);
            repeat (n - 1) add_token(1'b0);
        end
    endtask

    task automatic add_fill_stream();
        push_byte(BYTE_NL, 1'b1);
        gen_len = 0;
        while (gen_len < LIST_DEPTH) begin
            if (gen_len > 0 && $urandom_range(0, 5) == 0)
                add_code($urandom_range(0, gen_len - 1), 1'b0);
            else
                add_code($urandom_range(gen_len, LONG_ESC_OFS), 1'b0);
        end
        repeat (6) add_code($urandom_range(LIST_DEPTH, MAX_INDEX), 1'b0);
        add_code(LIST_DEPTH - 1, 1'b0);
        add_code(0, 1'b0);
        add_code(LIST_DEPTH - 1, 1'b0);
    endtask

    // ---------------- driver ----------------
    int tx_gap = 0;

    always @(posedge clk) begin
        t_token_out got;
        bit         has_tok;
        bit         calm;
        t_in_word   nx;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                has_tok = decode_byte(data_byte, stream_start, got);
                if (has_tok)
                    expected_tokens.push_back(got);
                n_sent++;
            end
            calm = pending.size() < TAIL_ITEMS || ((n_sent / 80) % 4 == 2);
            if (!in_valid || in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (pending.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    tx_gap = $urandom_range(1, 15) - 1;
                    in_valid <= 1'b0;
                end else begin
                    nx = pending.pop_front();
                    data_byte    <= nx.b;
                    stream_start <= nx.st;
                    in_valid     <= 1'b1;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int rx_gap     = 0;
    int rx_hold    = 0;
    bit stall_done = 1'b0;

    always @(posedge clk) begin
        t_token_out want;
        logic       nxt;
        bit         calm;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                n_seen++;
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind=%0d ord=%0d idx=%0d",
                                              token_kind, word_ordinal, code_index));
                end else begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                        report_mismatch($sformatf("word %0d kind %0d, want %0d",
                                                  n_seen, token_kind, want.kind));
                    if (word_ordinal !== want.ord)
                        report_mismatch($sformatf("word %0d ordinal %0d, want %0d",
                                                  n_seen, word_ordinal, want.ord));
                    if (code_index !== want.idx)
                        report_mismatch($sformatf("word %0d index %0d, want %0d",
                                                  n_seen, code_index, want.idx));
                end
            end
            calm = pending.size() < TAIL_ITEMS || ((n_seen / 64) % 4 == 1);
            if (rx_hold > 0) begin
                rx_hold--;
                nxt = 1'b0;
            end else if (!stall_done && n_seen >= 30) begin
                // long back-pressure so the token queue fills and input stalls
                stall_done = 1'b1;
                rx_hold    = STALL_LONG - 1;
                nxt        = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                nxt = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 15) - 1;
                nxt    = 1'b0;
            end else begin
                nxt = 1'b1;
            end
            out_ready <= nxt;
        end
    end

    // ---------------- run control ----------------
    initial begin : watchdog
        int unsigned cyc;
        cyc = 0;
        while (cyc < RUN_LIMIT) begin
            @(posedge clk);
            cyc++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        // directed: newline forms, text, short codes at both ends, both escapes
        push_byte(BYTE_NL, 1'b1);
        push_byte(BYTE_TEXT_END, 1'b0);
        push_byte(65, 1'b0);
        push_byte(0, 1'b0);
        push_byte(BYTE_TEXT_END - 1, 1'b0);
        push_byte(SHORT_BASE, 1'b0);
        push_byte(255, 1'b0);
        push_byte(SHORT_BASE, 1'b0);
        push_byte(SHORT_BASE + 1, 1'b0);
        push_byte(ESC_SHORT - 1, 1'b0);
        push_byte(ESC_LONG + 1, 1'b0);
        push_byte(ESC_SHORT, 1'b0);
        push_byte(0, 1'b0);
        push_byte(ESC_SHORT, 1'b0);
        push_byte(BYTE_NL, 1'b0);
        push_byte(ESC_SHORT, 1'b0);
        push_byte(255, 1'b0);
        push_byte(ESC_LONG, 1'b0);
        push_byte(0, 1'b0);
        push_byte(0, 1'b0);
        push_byte(ESC_LONG, 1'b0);
        push_byte(255, 1'b0);
        push_byte(255, 1'b0);
        push_byte(ESC_LONG, 1'b0);
        push_byte(BYTE_NL, 1'b0);
        push_byte(BYTE_TEXT_END, 1'b0);
        // stream restart in the middle of a long escape
        push_byte(ESC_LONG, 1'b0);
        push_byte(65, 1'b1);
        push_byte(SHORT_BASE + 2, 1'b0);

        add_streams(N_ITEMS * 2 / 5);
        add_fill_stream();
        add_streams(N_ITEMS);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending.size() != 0 || in_valid || expected_tokens.size() != 0);
        repeat (LIST_DEPTH + 40) @(posedge clk);

        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_tokens.size()));

        if (n_errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
